### rtl/fst_pkg.sv
// Shared constants, types and codes of the flow sequence tracker.
package fst_pkg;

  localparam int RESTART_LIMIT = 128;
  localparam int SLOT_W        = $clog2(RESTART_LIMIT);
  localparam int COUNT_W       = $clog2(RESTART_LIMIT + 1);

  localparam int ADDR_W = 32;
  localparam int PORT_W = 16;
  localparam int SEQ_W  = 32;
  localparam int TIME_W = 40;
  localparam int OSLOT_W = 7;

  localparam logic [TIME_W-1:0] STALE_LIMIT_RESET = TIME_W'(120000);

  typedef enum logic [2:0] {
    OUT_RESTART = 3'd0,
    OUT_NEW     = 3'd1,
    OUT_STALE   = 3'd2,
    OUT_ORDER   = 3'd3,
    OUT_INORDER = 3'd4
  } outcome_t;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_CHECK  = 5'b00100,
    S_DECIDE = 5'b01000,
    S_OUT    = 5'b10000
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0]        addr;
    logic [PORT_W-1:0]        port;
    logic signed [SEQ_W-1:0]  max_seq;
    logic [TIME_W-1:0]        last_seen;
  } entry_t;

  typedef struct packed {
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    entry_t            wr_data;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
  } ram_req_t;

  typedef struct packed {
    logic               busy;
    logic [COUNT_W-1:0] flow_count;
  } status_t;

endpackage

### rtl/fst_if.sv
// Channel interfaces: packet input, result output and register write.
interface fst_pkt_if
  import fst_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [ADDR_W-1:0]        src_addr;
  logic [PORT_W-1:0]        src_port;
  logic signed [SEQ_W-1:0]  seq_num;
  logic [TIME_W-1:0]        now_time;

  modport source (output valid, src_addr, src_port, seq_num, now_time, input ready);
  modport sink (input valid, src_addr, src_port, seq_num, now_time, output ready);
endinterface

interface fst_res_if
  import fst_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [2:0]               outcome;
  logic [OSLOT_W-1:0]       slot;
  logic signed [SEQ_W-1:0]  stored_max;

  modport source (output valid, outcome, slot, stored_max, input ready);
  modport sink (input valid, outcome, slot, stored_max, output ready);
endinterface

interface fst_cfg_if
  import fst_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] stale_limit;

  modport source (output valid, stale_limit, input ready);
  modport sink (input valid, stale_limit, output ready);
endinterface

### rtl/flow_sequence_tracker.sv
// Flow sequence tracker: per-client flow table with sequence and staleness checks.
// A restart writes slot 0 and goes straight to the output stage; other packets
// search the table one slot after another, then pass through the check and
// decide states on a match, or are appended as a new flow when none matches.
// One packet at a time; a linear table read, one entry per cycle, sets the rate.
// Reset clears the flow count, the state machine and the output valid flag, and
// loads stale_limit with 120000; table contents need no clearing.
module flow_sequence_tracker
  import fst_pkg::*;
(
  input logic       clk,
  input logic       rst,
  fst_pkt_if.sink   pkt,
  fst_res_if.source res,
  fst_cfg_if.sink   cfg
);

  logic [TIME_W-1:0] stale_limit;
  ram_req_t          ram_req;
  entry_t            rd_data;
  status_t           status;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stale_limit <= STALE_LIMIT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      stale_limit <= cfg.stale_limit;
    end
  end

  fst_flow_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  fst_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pkt         (pkt),
    .res         (res),
    .stale_limit (stale_limit),
    .ram_req     (ram_req),
    .rd_data     (rd_data),
    .status      (status)
  );

  // A packet beat always starts work on it.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (pkt.valid && pkt.ready) |=> status.busy)
    else $error("packet accepted but sequencer not busy");

  // After any packet the table holds at least one flow.
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    (pkt.valid && pkt.ready) |=> (status.flow_count != '0))
    else $error("flow count zero after a packet");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    status.flow_count <= COUNT_W'(RESTART_LIMIT))
    else $error("flow count above restart limit");

  // The table is written only on behalf of a packet in progress.
  a_write_owned: assert property (@(posedge clk) disable iff (rst)
    ram_req.wr_en |-> (status.busy || (pkt.valid && pkt.ready)))
    else $error("table write with no packet in progress");

endmodule

### rtl/fst_flow_ram.sv
// Flow table memory: one write port, one read port with registered data.
module fst_flow_ram
  import fst_pkg::*;
(
  input  logic     clk,
  input  ram_req_t req,
  output entry_t   rd_data
);

  entry_t mem [RESTART_LIMIT];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

### rtl/fst_ctrl.sv
// Search sequencer: walks the flow table, decides the outcome, writes back.
module fst_ctrl
  import fst_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  fst_pkt_if.sink           pkt,
  fst_res_if.source         res,
  input  logic [TIME_W-1:0] stale_limit,
  output ram_req_t          ram_req,
  input  entry_t            rd_data,
  output status_t           status
);

  state_t                  state;
  logic [SLOT_W-1:0]       idx;
  logic [COUNT_W-1:0]      flow_count;

  logic [ADDR_W-1:0]       p_addr;
  logic [PORT_W-1:0]       p_port;
  logic signed [SEQ_W-1:0] p_seq;
  logic [TIME_W-1:0]       p_now;

  logic signed [SEQ_W-1:0] h_seq;
  logic [TIME_W-1:0]       h_last;
  logic [TIME_W-1:0]       age;
  logic                    newer;

  outcome_t                r_outcome;
  logic [SLOT_W-1:0]       r_slot;
  logic signed [SEQ_W-1:0] r_prev;

  logic                    out_valid;
  outcome_t                out_outcome;
  logic [OSLOT_W-1:0]      out_slot;
  logic signed [SEQ_W-1:0] out_prev;

  logic accept;
  logic restart;
  logic match;
  logic last_slot;
  logic stale;
  logic order_err;
  logic out_load;

  assign accept    = pkt.valid && pkt.ready;
  assign restart   = (flow_count == '0) || (flow_count >= COUNT_W'(RESTART_LIMIT));
  assign match     = (rd_data.addr == p_addr) && (rd_data.port == p_port);
  assign last_slot = (COUNT_W'(idx) + COUNT_W'(1)) == flow_count;
  assign stale     = newer && (age > stale_limit);
  assign order_err = p_seq < h_seq;
  assign out_load  = (state == S_OUT) && (!out_valid || res.ready);

  assign pkt.ready = (state == S_IDLE);

  assign res.valid      = out_valid;
  assign res.outcome    = out_outcome;
  assign res.slot       = out_slot;
  assign res.stored_max = out_prev;

  assign status.busy       = (state != S_IDLE);
  assign status.flow_count = flow_count;

  always_comb begin
    ram_req = '0;
    case (state)
      S_IDLE: begin
        if (pkt.valid) begin
          if (restart) begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = '0;
            ram_req.wr_data = '{pkt.src_addr, pkt.src_port, pkt.seq_num, pkt.now_time};
          end else begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = '0;
          end
        end
      end
      S_SEARCH: begin
        if (!match) begin
          if (last_slot) begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = flow_count[SLOT_W-1:0];
            ram_req.wr_data = '{p_addr, p_port, p_seq, p_now};
          end else begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = idx + SLOT_W'(1);
          end
        end
      end
      S_DECIDE: begin
        // Stale refresh and in-order update store the same thing.
        if (stale || !order_err) begin
          ram_req.wr_en   = 1'b1;
          ram_req.wr_addr = idx;
          ram_req.wr_data = '{p_addr, p_port, p_seq, p_now};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      flow_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            p_addr <= pkt.src_addr;
            p_port <= pkt.src_port;
            p_seq  <= pkt.seq_num;
            p_now  <= pkt.now_time;
            idx    <= '0;
            if (restart) begin
              flow_count <= COUNT_W'(1);
              r_outcome  <= OUT_RESTART;
              r_slot     <= '0;
              r_prev     <= '0;
              state      <= S_OUT;
            end else begin
              state <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (match) begin
            h_seq  <= rd_data.max_seq;
            h_last <= rd_data.last_seen;
            state  <= S_CHECK;
          end else if (last_slot) begin
            flow_count <= flow_count + COUNT_W'(1);
            r_outcome  <= OUT_NEW;
            r_slot     <= flow_count[SLOT_W-1:0];
            r_prev     <= '0;
            state      <= S_OUT;
          end else begin
            idx <= idx + SLOT_W'(1);
          end
        end
        S_CHECK: begin
          // A timestamp behind the stored one never counts as stale.
          newer <= p_now > h_last;
          age   <= p_now - h_last;
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          r_slot <= idx;
          if (stale) begin
            r_outcome <= OUT_STALE;
            r_prev    <= '0;
          end else if (order_err) begin
            r_outcome <= OUT_ORDER;
            r_prev    <= h_seq;
          end else begin
            r_outcome <= OUT_INORDER;
            r_prev    <= '0;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_outcome <= r_outcome;
      out_slot    <= OSLOT_W'(r_slot);
      out_prev    <= r_prev;
    end
  end

endmodule

### sim/flow_sequence_tracker_test.sv
// Self-checking testbench for the flow sequence tracker: flow table, staleness and ordering.
`timescale 1ns / 100ps

module flow_sequence_tracker_test
  import fst_pkg::*;
;

  localparam int NKEYS = 10;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // Tracks the flow table the block should hold and the results it owes.
  class flow_scoreboard;
    typedef struct {
      outcome_t                outcome;
      logic [OSLOT_W-1:0]      slot;
      logic signed [SEQ_W-1:0] stored_max;
    } verdict_t;

    logic [TIME_W-1:0] stale_limit = STALE_LIMIT_RESET;
    int unsigned       flow_count  = 0;
    entry_t            flows[RESTART_LIMIT];
    verdict_t          owed_q[$];
    int                errors      = 0;

    function void put_flow(int idx, logic [ADDR_W-1:0] addr, logic [PORT_W-1:0] port,
                           logic signed [SEQ_W-1:0] seq, logic [TIME_W-1:0] now);
      flows[idx].addr      = addr;
      flows[idx].port      = port;
      flows[idx].max_seq   = seq;
      flows[idx].last_seen = now;
    endfunction

    function void note_packet(logic [ADDR_W-1:0] addr, logic [PORT_W-1:0] port,
                              logic signed [SEQ_W-1:0] seq, logic [TIME_W-1:0] now);
      verdict_t v;
      int hit;
      v.outcome    = OUT_RESTART;
      v.slot       = '0;
      v.stored_max = '0;
      hit = -1;
      if (flow_count == 0 || flow_count >= RESTART_LIMIT) begin
        put_flow(0, addr, port, seq, now);
        flow_count = 1;
      end else begin
        for (int i = 0; i < flow_count; i++) begin
          if (hit < 0 && flows[i].addr == addr && flows[i].port == port) hit = i;
        end
        if (hit < 0) begin
          v.outcome = OUT_NEW;
          v.slot    = OSLOT_W'(flow_count);
          put_flow(flow_count, addr, port, seq, now);
          flow_count++;
        end else begin
          v.slot = OSLOT_W'(hit);
          // A timestamp behind the stored one never makes the flow stale.
          if (now > flows[hit].last_seen &&
              (now - flows[hit].last_seen) > stale_limit) begin
            v.outcome = OUT_STALE;
            put_flow(hit, addr, port, seq, now);
          end else if (seq < flows[hit].max_seq) begin
            v.outcome    = OUT_ORDER;
            v.stored_max = flows[hit].max_seq;
          end else begin
            v.outcome = OUT_INORDER;
            put_flow(hit, addr, port, seq, now);
          end
        end
      end
      owed_q.push_back(v);
    endfunction

    function void check_result(logic [2:0] outcome, logic [OSLOT_W-1:0] slot,
                               logic signed [SEQ_W-1:0] stored_max);
      verdict_t w;
      if (owed_q.size() == 0) begin
        $error("result beat with no packet outstanding: outcome %0d slot %0d",
               outcome, slot);
        errors++;
        return;
      end
      w = owed_q.pop_front();
      if (outcome !== w.outcome) begin
        $error("outcome: expected %0d, actual %0d", w.outcome, outcome);
        errors++;
      end
      if (slot !== w.slot) begin
        $error("slot: expected %0d, actual %0d", w.slot, slot);
        errors++;
      end
      if (stored_max !== w.stored_max) begin
        $error("stored_max: expected %0d, actual %0d", w.stored_max, stored_max);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  fst_pkt_if pkt_ch ();
  fst_res_if res_ch ();
  fst_cfg_if cfg_ch ();

  flow_sequence_tracker uut (
    .clk (clk),
    .rst (rst),
    .pkt (pkt_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  flow_scoreboard sb = new();

  always #1 clk = ~clk;

  // Every beat on the packet and result channels goes to the scoreboard.
  always @(posedge clk) begin
    if (!rst) begin
      if (pkt_ch.valid && pkt_ch.ready)
        sb.note_packet(pkt_ch.src_addr, pkt_ch.src_port, pkt_ch.seq_num, pkt_ch.now_time);
      if (res_ch.valid && res_ch.ready)
        sb.check_result(res_ch.outcome, res_ch.slot, res_ch.stored_max);
    end
  end

  int cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("flow_sequence_tracker_test NOT OK");
      $finish;
    end
  end

  // The receiver replays a rotating 16-bit ready pattern that is reloaded now and then.
  // At least one bit is set, so no stall lasts a whole turn of the pattern.
  logic [15:0] ready_pat = 16'hFFFF;
  int          pat_age   = 0;
  always @(posedge clk) begin
    if (pat_age == 0) begin
      pat_age   <= $urandom_range(80, 20);
      ready_pat <= ($urandom_range(3, 0) == 0) ? 16'hFFFF : 16'($urandom_range(65535, 1));
      res_ch.ready <= 1'b1;
    end else begin
      pat_age   <= pat_age - 1;
      ready_pat <= {ready_pat[0], ready_pat[15:1]};
      res_ch.ready <= ready_pat[0];
    end
  end

  logic [ADDR_W-1:0]       key_addr[NKEYS];
  logic [PORT_W-1:0]       key_port[NKEYS];
  logic signed [SEQ_W-1:0] key_seq[NKEYS];
  logic [TIME_W-1:0]       clock_ms = '0;
  int                      burst_left = 0;

  function automatic logic [TIME_W-1:0] rand_time();
    return {8'($urandom_range(255, 0)), 32'($urandom())};
  endfunction

  task automatic send_pkt(logic [ADDR_W-1:0] a, logic [PORT_W-1:0] p,
                          logic signed [SEQ_W-1:0] s, logic [TIME_W-1:0] t);
    pkt_ch.valid    <= 1'b1;
    pkt_ch.src_addr <= a;
    pkt_ch.src_port <= p;
    pkt_ch.seq_num  <= s;
    pkt_ch.now_time <= t;
    @(posedge clk);
    while (!pkt_ch.ready) @(posedge clk);
  endtask

  // Bursts of random length with random gaps; a calm stretch never drops valid.
  task automatic pace(bit calm);
    int gap;
    if (calm) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(12, 0);
    gap = ($urandom_range(9, 0) == 0) ? $urandom_range(25, 8) : $urandom_range(4, 0);
    if (gap > 0) begin
      pkt_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Waits on the clock before the check, so that the last accepted packet is surely on the scoreboard.
  task automatic settle();
    pkt_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.owed_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(logic [TIME_W-1:0] v);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.stale_limit <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid   <= 1'b0;
    sb.stale_limit = v;
  endtask

  // Mostly well-formed traffic on a small set of flows: rising sequences and
  // time, with some reordering, repeats, stale jumps and clock steps backward.
  task automatic run_phase(logic [TIME_W-1:0] limit, int n, int unsigned dt_max,
                           int fresh_pct, bit calm);
    int k;
    int r;
    logic signed [SEQ_W-1:0] s;
    settle();
    write_limit(limit);
    for (int j = 0; j < NKEYS; j++) begin
      key_addr[j] = $urandom();
      key_port[j] = 16'($urandom_range(65535, 0));
      key_seq[j]  = $urandom();
    end
    key_addr[1] = key_addr[0];
    key_port[2] = key_port[3];
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(NKEYS - 1, 0);
      if ($urandom_range(99, 0) < fresh_pct) begin
        key_addr[k] = $urandom();
        key_port[k] = 16'($urandom_range(65535, 0));
      end
      r = $urandom_range(99, 0);
      if (r < 65) begin
        key_seq[k] = key_seq[k] + SEQ_W'($urandom_range(20, 1));
        s = key_seq[k];
      end else if (r < 75) begin
        s = key_seq[k];
      end else if (r < 90) begin
        s = key_seq[k] - SEQ_W'($urandom_range(50, 1));
      end else begin
        s = $urandom();
        key_seq[k] = s;
      end
      r = $urandom_range(99, 0);
      if (r < 80)
        clock_ms = clock_ms + TIME_W'($urandom_range(dt_max, 0));
      else if (r < 90)
        clock_ms = clock_ms + limit + TIME_W'($urandom_range(3, 1));
      else if (r < 95)
        clock_ms = clock_ms - TIME_W'($urandom_range(1000, 1));
      else
        clock_ms = rand_time();
      send_pkt(key_addr[k], key_port[k], s, clock_ms);
      pace(calm);
    end
  endtask

  // Fresh flows until the table fills and restarts, with repeats of earlier
  // ones so that matches are found deep in the table.
  task automatic fill_flows(int n);
    logic [ADDR_W-1:0] fa[$];
    logic [PORT_W-1:0] fp[$];
    int k;
    settle();
    write_limit(STALE_LIMIT_RESET);
    for (int i = 0; i < n; i++) begin
      clock_ms = clock_ms + 1;
      if (i % 8 == 7) begin
        k = $urandom_range(fa.size() - 1, 0);
        send_pkt(fa[k], fp[k], $urandom(), clock_ms);
      end else begin
        fa.push_back($urandom());
        fp.push_back(16'($urandom_range(65535, 0)));
        send_pkt(fa[$], fp[$], $urandom(), clock_ms);
      end
      pace(1'b0);
    end
  endtask

  localparam logic [ADDR_W-1:0] KA = 32'h0A00_0001;

  initial begin
    rst                <= 1'b1;
    pkt_ch.valid       <= 1'b0;
    pkt_ch.src_addr    <= '0;
    pkt_ch.src_port    <= '0;
    pkt_ch.seq_num     <= '0;
    pkt_ch.now_time    <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.stale_limit <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset stale limit.
    send_pkt(KA, 16'd5000, 32'sd0, 40'd0);
    pace(1'b0);
    send_pkt(KA, 16'd5000, 32'sd5, 40'd10);
    pace(1'b0);
    send_pkt(KA, 16'd5000, 32'sd5, 40'd20);
    send_pkt(KA, 16'd5000, 32'sd3, 40'd30);
    send_pkt(32'hFFFF_FFFF, 16'hFFFF, 32'sh7FFF_FFFF, 40'd100);
    send_pkt(32'hFFFF_FFFF, 16'hFFFF, 32'sh8000_0000, 40'd110);
    pace(1'b0);
    send_pkt(32'h0, 16'h0, 32'sh8000_0000, 40'd120);
    send_pkt(32'h0, 16'h0, -32'sd1, 40'd130);
    // Age exactly at the limit is not stale; one past it is.
    send_pkt(KA, 16'd5000, 32'sd6, 40'd120020);
    send_pkt(KA, 16'd5000, -32'sd100, 40'd240021);
    // Time going backwards is never stale.
    send_pkt(KA, 16'd5000, -32'sd200, 40'd0);
    send_pkt(KA, 16'd5000, -32'sd50, TIME_MAX);
    pace(1'b0);
    send_pkt(KA, 16'd5001, 32'sd1, 40'd5);
    send_pkt(KA ^ 32'h1, 16'd5000, 32'sd1, 40'd5);
    send_pkt(32'h0, 16'h0, 32'sh7FFF_FFFF, 40'd0);
    settle();
    write_limit('0);
    send_pkt(32'h0, 16'h0, 32'sd0, 40'd0);
    send_pkt(32'h0, 16'h0, 32'sd0, 40'd1);
    settle();
    write_limit(TIME_MAX);
    send_pkt(KA, 16'd5000, -32'sd60, 40'd0);
    send_pkt(32'hFFFF_FFFF, 16'hFFFF, 32'sd0, TIME_MAX);

    // Random part.
    run_phase('0, 60, 2, 5, 1'b0);
    run_phase(40'd50, 80, 30, 8, 1'b1);
    run_phase(TIME_MAX, 40, 1000000, 5, 1'b0);
    run_phase(rand_time(), 60, 100000, 10, 1'b0);
    fill_flows(150);
    run_phase(STALE_LIMIT_RESET, 60, 50000, 10, 1'b0);

    settle();
    repeat (140) @(posedge clk);
    if (sb.errors == 0 && sb.owed_q.size() == 0)
      $display("flow_sequence_tracker_test OK");
    else
      $display("flow_sequence_tracker_test NOT OK");
    $finish;
  end

endmodule
